### rtl/bfm_pkg.sv
// Package for the battery fault monitor: payload structs, pack state and
// fault bit codes, register indexes and fixed monitor constants.
// No dependencies; used by battery_fault_monitor.
`default_nettype none

package bfm_pkg;

   // Fixed configuration of the monitor
   localparam int NUM_CELLS   = 4;
   localparam int CELL_FIELDS = 4;
   localparam int CELLS_USED  = (NUM_CELLS < CELL_FIELDS) ? NUM_CELLS : CELL_FIELDS;

   localparam logic [7:0]         DEBOUNCE_TICKS        = 8'd3;
   localparam logic [7:0]         SENSOR_DEBOUNCE_TICKS = 8'd3;
   localparam logic [15:0]        CELL_MIN_MV           = 16'd500;
   localparam logic [15:0]        CELL_MAX_MV           = 16'd5000;
   localparam logic signed [24:0] DEADBAND_MA           = 25'sd50;

   // Monitor slots and fault mask bits
   localparam int MON_N  = 5;
   localparam int MON_OV = 0;
   localparam int MON_UV = 1;
   localparam int MON_OT = 2;
   localparam int MON_OC = 3;
   localparam int MON_SN = 4;

   // Pack state codes as reported on the result channel
   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CHG   = 3'd2;
   localparam logic [2:0] ST_DSG   = 3'd3;
   localparam logic [2:0] ST_FAULT = 3'd4;

   // Item kinds
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // Register indexes and port widths
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_OV_TRIP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OV_RELEASE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UV_TRIP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UV_RELEASE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OT_TRIP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OT_RELEASE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OC_DSG     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_OC_CHG     = 3'd7;

   typedef struct packed {
      logic               kind;
      logic [15:0]        cell_mv_0;
      logic [15:0]        cell_mv_1;
      logic [15:0]        cell_mv_2;
      logic [15:0]        cell_mv_3;
      logic signed [15:0] temp_dc;
      logic signed [23:0] pack_cur_ma;
   } req_type;

   typedef struct packed {
      logic [2:0]  pack_state;
      logic [4:0]  fault_mask;
      logic [15:0] vmin_mv;
      logic [15:0] vmax_mv;
      logic        fets_on;
      logic        clear_ok;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/battery_fault_monitor.sv
// Battery pack fault monitor top level: input register, one pass of monitor
// logic, result register. Depends on bfm_pkg.
//
// Usage:
//   req_valid/req_stall/req_data carry one item: a measurement tick with four
//   cell voltages, temperature and current, or a request to clear latched
//   faults. Every item produces exactly one result on rsp_valid/rsp_stall/
//   rsp_data: pack state, latched fault mask, min/max valid cell voltage,
//   FET enable and the clear acknowledge.
//   An accepted item passes through the input register and then the result
//   register before rsp_valid rises. Throughput is one item per cycle while
//   rsp_stall is low: the input register and the result register are
//   separate, and the monitor state updates in the same cycle an item moves
//   from one to the other.
//   When the receiver stalls, the result register holds its beat and the
//   item behind it stays in the input register; req_stall rises only while
//   both are full and rsp_stall is high.
//   Synchronous reset loads the threshold registers with their defaults,
//   clears debounce counters, active and latched faults, and sets the state
//   to init. Thresholds are written through csr_wr_en/csr_index/csr_wdata,
//   one register per cycle; user must keep no item in flight (unenforced).
`default_nettype none

module battery_fault_monitor (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  bfm_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output bfm_pkg::rsp_type                    rsp_data,
   input  wire                                 csr_wr_en,
   input  wire  [bfm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [bfm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Threshold registers
   logic [15:0]        ov_trip_ff, ov_release_ff, uv_trip_ff, uv_release_ff;
   logic signed [15:0] ot_trip_ff, ot_release_ff;
   logic signed [23:0] oc_dsg_ff, oc_chg_ff;

   // Pipeline registers
   logic             in_valid_ff, in_valid_in;
   bfm_pkg::req_type in_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   bfm_pkg::rsp_type rsp_ff, rsp_in;
   logic             req_accept, advance;

   // Monitor state
   logic [7:0]               count_ff [bfm_pkg::MON_N];
   logic [7:0]               count_in [bfm_pkg::MON_N];
   logic [bfm_pkg::MON_N-1:0] active_ff, active_in;
   logic [bfm_pkg::MON_N-1:0] latched_ff, latched_in;
   logic [2:0]               mode_ff, mode_in;
   logic signed [23:0]       last_cur_ff, last_cur_in;
   logic [15:0]              vmin_ff, vmin_in, vmax_ff, vmax_in;

   // Per-tick working values
   logic [15:0]        cell_mv [bfm_pkg::CELL_FIELDS];
   logic [15:0]        vmin, vmax;
   logic               any_ok, bad;
   logic signed [15:0] temp;
   logic signed [23:0] cur;
   logic               oc_cond, clear_ok;
   logic [bfm_pkg::MON_N-1:0] trip, rel, upd;
   logic [7:0]         deb [bfm_pkg::MON_N];
   logic [7:0]         cnt_inc [bfm_pkg::MON_N];

   function automatic logic [2:0] pick_mode(input logic [bfm_pkg::MON_N-1:0] faults,
                                            input logic signed [23:0] current);
      logic signed [24:0] c;
      c = 25'(current);
      if (faults != '0)
         return bfm_pkg::ST_FAULT;
      else if (c >= bfm_pkg::DEADBAND_MA)
         return bfm_pkg::ST_CHG;
      else if (c <= -bfm_pkg::DEADBAND_MA)
         return bfm_pkg::ST_DSG;
      else
         return bfm_pkg::ST_IDLE;
   endfunction

   // Handshake: the input register advances whenever the result slot frees
   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   // Min/max over valid cells
   always_comb begin
      cell_mv[0] = in_ff.cell_mv_0;
      cell_mv[1] = in_ff.cell_mv_1;
      cell_mv[2] = in_ff.cell_mv_2;
      cell_mv[3] = in_ff.cell_mv_3;
      any_ok = 1'b0;
      bad    = 1'b0;
      vmin   = 16'hFFFF;
      vmax   = 16'h0000;
      for (int i = 0; i < bfm_pkg::CELLS_USED; i++) begin
         if (cell_mv[i] < bfm_pkg::CELL_MIN_MV || cell_mv[i] > bfm_pkg::CELL_MAX_MV) begin
            bad = 1'b1;
         end else begin
            any_ok = 1'b1;
            if (cell_mv[i] < vmin) vmin = cell_mv[i];
            if (cell_mv[i] > vmax) vmax = cell_mv[i];
         end
      end
      if (!any_ok) begin
         vmin = 16'h0000;
         vmax = 16'h0000;
      end
   end

   // Trip and release conditions; OV/UV hold when no cell is valid
   always_comb begin
      temp    = in_ff.temp_dc;
      cur     = in_ff.pack_cur_ma;
      oc_cond = (cur <= oc_dsg_ff) || (cur >= oc_chg_ff);

      trip[bfm_pkg::MON_OV] = vmax >= ov_trip_ff;
      rel[bfm_pkg::MON_OV]  = vmax <= ov_release_ff;
      trip[bfm_pkg::MON_UV] = vmin <= uv_trip_ff;
      rel[bfm_pkg::MON_UV]  = vmin >= uv_release_ff;
      trip[bfm_pkg::MON_OT] = temp >= ot_trip_ff;
      rel[bfm_pkg::MON_OT]  = temp <= ot_release_ff;
      trip[bfm_pkg::MON_OC] = oc_cond;
      rel[bfm_pkg::MON_OC]  = !oc_cond;
      trip[bfm_pkg::MON_SN] = bad;
      rel[bfm_pkg::MON_SN]  = !bad;

      upd = '1;
      upd[bfm_pkg::MON_OV] = any_ok;
      upd[bfm_pkg::MON_UV] = any_ok;

      for (int m = 0; m < bfm_pkg::MON_N; m++) begin
         deb[m]     = (m == bfm_pkg::MON_SN) ? bfm_pkg::SENSOR_DEBOUNCE_TICKS
                                             : bfm_pkg::DEBOUNCE_TICKS;
         cnt_inc[m] = count_ff[m] + 8'd1;
      end
   end

   // State update for the item moving into the result register
   always_comb begin
      count_in    = count_ff;
      active_in   = active_ff;
      latched_in  = latched_ff;
      mode_in     = mode_ff;
      last_cur_in = last_cur_ff;
      vmin_in     = vmin_ff;
      vmax_in     = vmax_ff;
      clear_ok    = 1'b0;

      if (advance) begin
         if (in_ff.kind == bfm_pkg::KIND_CLEAR) begin
            if (latched_ff == '0) begin
               clear_ok = 1'b1;
            end else if (active_ff == '0) begin
               latched_in = '0;
               mode_in    = pick_mode('0, last_cur_ff);
               clear_ok   = 1'b1;
            end
         end else begin
            vmin_in     = vmin;
            vmax_in     = vmax;
            last_cur_in = cur;
            for (int m = 0; m < bfm_pkg::MON_N; m++) begin
               if (upd[m]) begin
                  if (active_ff[m]) begin
                     if (rel[m]) active_in[m] = 1'b0;
                     count_in[m] = 8'd0;
                  end else if (trip[m]) begin
                     if (cnt_inc[m] >= deb[m]) begin
                        active_in[m] = 1'b1;
                        count_in[m]  = 8'd0;
                     end else begin
                        count_in[m] = cnt_inc[m];
                     end
                  end else begin
                     count_in[m] = 8'd0;
                  end
               end
            end
            latched_in = latched_ff | active_in;
            mode_in    = pick_mode(latched_in, cur);
         end
      end

      rsp_in.pack_state = mode_in;
      rsp_in.fault_mask = latched_in;
      rsp_in.vmin_mv    = vmin_in;
      rsp_in.vmax_mv    = vmax_in;
      rsp_in.fets_on    = (mode_in == bfm_pkg::ST_IDLE) || (mode_in == bfm_pkg::ST_CHG) ||
                          (mode_in == bfm_pkg::ST_DSG);
      rsp_in.clear_ok   = clear_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int m = 0; m < bfm_pkg::MON_N; m++) count_ff[m] <= 8'd0;
         active_ff    <= '0;
         latched_ff   <= '0;
         mode_ff      <= bfm_pkg::ST_INIT;
         last_cur_ff  <= '0;
         vmin_ff      <= '0;
         vmax_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         latched_ff   <= latched_in;
         mode_ff      <= mode_in;
         last_cur_ff  <= last_cur_in;
         vmin_ff      <= vmin_in;
         vmax_ff      <= vmax_in;
      end
   end

   // Payload registers: input loads on accept, result on advance, else hold
   always_ff @(posedge clock) begin
      if (req_accept) in_ff <= req_data;
      if (advance)    rsp_ff <= rsp_in;
   end

   // Threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_trip_ff    <= 16'd4250;
         ov_release_ff <= 16'd4150;
         uv_trip_ff    <= 16'd2800;
         uv_release_ff <= 16'd3000;
         ot_trip_ff    <= 16'sd600;
         ot_release_ff <= 16'sd550;
         oc_dsg_ff     <= -24'sd50000;
         oc_chg_ff     <= 24'sd20000;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bfm_pkg::CSR_OV_TRIP:    ov_trip_ff    <= csr_wdata[15:0];
            bfm_pkg::CSR_OV_RELEASE: ov_release_ff <= csr_wdata[15:0];
            bfm_pkg::CSR_UV_TRIP:    uv_trip_ff    <= csr_wdata[15:0];
            bfm_pkg::CSR_UV_RELEASE: uv_release_ff <= csr_wdata[15:0];
            bfm_pkg::CSR_OT_TRIP:    ot_trip_ff    <= csr_wdata[15:0];
            bfm_pkg::CSR_OT_RELEASE: ot_release_ff <= csr_wdata[15:0];
            bfm_pkg::CSR_OC_DSG:     oc_dsg_ff     <= csr_wdata[23:0];
            bfm_pkg::CSR_OC_CHG:     oc_chg_ff     <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire
